[rtl/core/pwm_period_duty_meter_core_macros.svh]
// assertion macros shared by the meter core modules
// expects i_clk and i_rst_n in the module that uses them
`ifndef PWM_PERIOD_DUTY_METER_CORE_MACROS_SVH
`define PWM_PERIOD_DUTY_METER_CORE_MACROS_SVH

// condition holds at every edge out of reset
`define PDM_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// antecedent at one edge implies consequent at the next
`define PDM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/pdm_pkg.sv]
// types and constants for the pwm period and duty meter core
// no dependencies
package pdm_pkg;

    localparam int PORT_W     = 8;
    localparam int SEL_W      = 3;
    localparam int CNT_W      = 15;
    localparam int TIME_W     = 16;
    localparam int SUM_W      = TIME_W + 1;
    localparam int PCT_W      = 7;
    localparam int PROD_W     = TIME_W + PCT_W;
    localparam int QUOT_W     = 7;
    localparam int QCNT_W     = 3;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 15;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;

    localparam logic [PCT_W-1:0] PERCENT       = 7'd100;
    localparam logic [CNT_W-1:0] TIMEOUT_RESET = 15'd5000;

    localparam logic [CFG_ADDR_W-1:0] REG_CHANNEL_SELECT = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ACTIVE_LEVEL   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_PERIOD_MODE    = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_TIMEOUT_TICKS  = 2'd3;

    typedef struct packed {
        logic accept;
        logic div_step;
        logic out_load;
    } t_ctrl_cmd;

    typedef struct packed {
        logic need_div;
        logic div_last;
        logic out_free;
    } t_dp_status;

endpackage

[rtl/core/pdm_ctrl.sv]
// sequencer for the meter core: accept, divide, load output
// depends on pdm_pkg and the assertion macro header
`include "pwm_period_duty_meter_core_macros.svh"

module pdm_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  pdm_pkg::t_dp_status i_status,
    output pdm_pkg::t_ctrl_cmd  o_cmd
);
    import pdm_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    assign o_s_tready     = (r_state == ST_IDLE);
    assign o_cmd.accept   = (r_state == ST_IDLE) && i_s_tvalid;
    assign o_cmd.div_step = (r_state == ST_DIV);
    assign o_cmd.out_load = (r_state == ST_DONE) && i_status.out_free;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = i_status.need_div ? ST_DIV : ST_DONE;
                end
            end
            ST_DIV: begin
                if (i_status.div_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `PDM_ASSERT_NEXT(a_accept_leaves_idle, o_cmd.accept, r_state != ST_IDLE, "accept stayed idle")
    `PDM_ASSERT_NEXT(a_load_returns_idle, o_cmd.out_load, r_state == ST_IDLE, "load not idle")
    `PDM_ASSERT(a_no_accept_busy, !(o_cmd.accept && (o_cmd.div_step || o_cmd.out_load)), "overlap")

endmodule

[rtl/core/pdm_datapath.sv]
// config registers, run counters, stuck flags, percent divider and output register
// depends on pdm_pkg and the assertion macro header
`include "pwm_period_duty_meter_core_macros.svh"

module pdm_datapath (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [pdm_pkg::CFG_ADDR_W-1:0]        i_cfg_addr,
    input  logic [pdm_pkg::CFG_DATA_W-1:0]        i_cfg_wdata,
    input  logic [pdm_pkg::IN_TDATA_W-1:0]        i_s_tdata,
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    output logic [pdm_pkg::OUT_TDATA_W-1:0]       o_m_tdata,
    input  pdm_pkg::t_ctrl_cmd                    i_cmd,
    output pdm_pkg::t_dp_status                   o_status
);
    import pdm_pkg::*;

    logic [SEL_W-1:0]  r_chan;
    logic              r_act_lvl;
    logic              r_period;
    logic [CNT_W-1:0]  r_timeout;

    logic [CNT_W-1:0]  r_acnt, n_acnt;
    logic [CNT_W-1:0]  r_icnt, n_icnt;
    logic              r_aseen, n_aseen;
    logic              r_iseen, n_iseen;
    logic [TIME_W-1:0] r_held, n_held;
    logic              r_stk_a, n_stk_a;
    logic              r_stk_i, n_stk_i;
    logic              r_res_mv, n_res_mv;
    logic [TIME_W-1:0] r_res_val, n_res_val;

    logic [PROD_W-1:0] r_rem;
    logic [PROD_W-1:0] r_dsh;
    logic [QUOT_W-1:0] r_quot;
    logic [QCNT_W-1:0] r_qcnt;
    logic              r_zero;

    logic              r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    logic              line_on;
    logic [CNT_W-1:0]  acnt_inc;
    logic [CNT_W-1:0]  icnt_inc;
    logic [SUM_W-1:0]  sum;
    logic [PROD_W-1:0] prod;
    logic              ge;
    logic [QUOT_W-1:0] quot_next;

    assign line_on  = (i_s_tdata[r_chan] == r_act_lvl);
    assign acnt_inc = r_acnt + 1'b1;
    assign icnt_inc = r_icnt + 1'b1;
    assign sum      = {1'b0, r_held} + {{(SUM_W-CNT_W){1'b0}}, r_icnt};
    assign prod     = PROD_W'(r_held) * PROD_W'(PERCENT);
    assign ge       = (r_rem >= r_dsh);
    assign quot_next = {r_quot[QUOT_W-2:0], ge};

    assign o_status.need_div = line_on && r_iseen && !r_period;
    assign o_status.div_last = (r_qcnt == '0);
    assign o_status.out_free = !r_out_valid || i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // tick update
    always_comb begin
        n_acnt    = r_acnt;
        n_icnt    = r_icnt;
        n_aseen   = r_aseen;
        n_iseen   = r_iseen;
        n_held    = r_held;
        n_stk_a   = r_stk_a;
        n_stk_i   = r_stk_i;
        n_res_mv  = 1'b0;
        n_res_val = '0;
        if (line_on) begin
            n_aseen = 1'b1;
            if (acnt_inc == r_timeout) begin
                n_stk_a = 1'b1;
                n_acnt  = '0;
            end else begin
                n_acnt = acnt_inc;
            end
            if (r_iseen) begin
                n_stk_i  = 1'b0;
                n_res_mv = 1'b1;
                if (r_period) begin
                    n_held    = sum[TIME_W-1:0];
                    n_res_val = sum[TIME_W-1:0];
                end
                n_icnt  = '0;
                n_iseen = 1'b0;
            end
        end else begin
            if (r_aseen) begin
                n_stk_a = 1'b0;
                n_held  = {{(TIME_W-CNT_W){1'b0}}, r_acnt};
                n_acnt  = '0;
                n_aseen = 1'b0;
            end
            n_iseen = 1'b1;
            if (icnt_inc == r_timeout) begin
                n_stk_i = 1'b1;
                n_icnt  = '0;
            end else begin
                n_icnt = icnt_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan    <= '0;
            r_act_lvl <= 1'b1;
            r_period  <= 1'b0;
            r_timeout <= TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_CHANNEL_SELECT: r_chan    <= i_cfg_wdata[SEL_W-1:0];
                REG_ACTIVE_LEVEL:   r_act_lvl <= i_cfg_wdata[0];
                REG_PERIOD_MODE:    r_period  <= i_cfg_wdata[0];
                REG_TIMEOUT_TICKS:  r_timeout <= i_cfg_wdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acnt  <= '0;
            r_icnt  <= '0;
            r_aseen <= 1'b0;
            r_iseen <= 1'b0;
            r_held  <= '0;
            r_stk_a <= 1'b0;
            r_stk_i <= 1'b0;
        end else if (i_cmd.accept) begin
            r_acnt  <= n_acnt;
            r_icnt  <= n_icnt;
            r_aseen <= n_aseen;
            r_iseen <= n_iseen;
            r_held  <= n_held;
            r_stk_a <= n_stk_a;
            r_stk_i <= n_stk_i;
        end
    end

    // restoring percent divider, one quotient bit a cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_res_mv  <= n_res_mv;
            r_res_val <= n_res_val;
            r_rem     <= prod;
            r_dsh     <= {sum, {(PROD_W-SUM_W){1'b0}}};
            r_quot    <= '0;
            r_qcnt    <= QCNT_W'(QUOT_W - 1);
            r_zero    <= (sum == '0);
        end else if (i_cmd.div_step) begin
            if (ge) begin
                r_rem <= r_rem - r_dsh;
            end
            r_dsh  <= r_dsh >> 1;
            r_quot <= quot_next;
            r_qcnt <= r_qcnt - 1'b1;
            if (o_status.div_last) begin
                r_res_val <= r_zero ? '0 : {{(TIME_W-QUOT_W){1'b0}}, quot_next};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= {{(OUT_TDATA_W-TIME_W-3){1'b0}}, r_res_val, r_res_mv, r_stk_i, r_stk_a};
        end
    end

    `PDM_ASSERT_NEXT(a_load_sets_valid, i_cmd.out_load, r_out_valid, "output word not raised")
    `PDM_ASSERT_NEXT(a_duty_in_range, i_cmd.div_step && o_status.div_last,
        r_res_val <= TIME_W'(PERCENT), "duty above full scale")

endmodule

[rtl/core/pwm_period_duty_meter_core.sv]
// pwm period and duty meter core: one result word per sampled tick word
// depends on pdm_pkg, pdm_ctrl and pdm_datapath
// the DONE state loads the result into the output register after accept, and when a
// duty percent is due the 7-step restoring divider runs first, one quotient bit a cycle
// a new word is taken only after the last is loaded, which waits while the output is full
// reset: synchronous active low; config to defaults, counters, flags and output valid cleared
module pwm_period_duty_meter_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [pdm_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  logic [pdm_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [pdm_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // port_bits
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // stuck_active, stuck_inactive, measure_valid, measure_value[15:0]
    output logic [pdm_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
    import pdm_pkg::*;

    t_ctrl_cmd  cmd;
    t_dp_status status;

    pdm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    pdm_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tdata   (s_axis_tdata),
        .o_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .o_m_tdata   (m_axis_tdata),
        .i_cmd       (cmd),
        .o_status    (status)
    );

endmodule
